// ===== rtl/vrsm_pkg.sv =====
// Shared types, constants, gain table and saturation helper for the volume ramp mixer.
`default_nettype none

package vrsm_pkg;

    localparam int DEF_FRACTION_BITS = 24;

    // Sample pair field widths and limits
    localparam int SAMPLE_W   = 16;
    localparam int GAIN_W     = 16;
    localparam int IDX_W      = 7;
    localparam int MS_W       = 16;
    localparam int CNT_W      = 22;
    localparam int PROD_W     = SAMPLE_W + GAIN_W + 1;

    localparam logic [MS_W-1:0]  MAX_RAMP_MS  = 16'd60000;
    localparam logic [IDX_W-1:0] RESET_TARGET = 7'd127;

    // Configuration register indexes
    localparam logic CFG_MONO_OUTPUT = 1'b0;
    localparam logic CFG_RATE_IS_48K = 1'b1;

    // Input transaction kinds
    localparam logic CMD_SAMPLE = 1'b0;
    localparam logic CMD_VOLUME = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_PREP,
        S_DIV,
        S_DSET,
        S_STEP,
        S_GAIN,
        S_MUL_L,
        S_MUL_R,
        S_FIN
    } t_state;

    localparam logic [GAIN_W-1:0] GAIN_ROM [0:127] = '{
        16'd0,     16'd2,     16'd8,     16'd18,    16'd32,    16'd50,    16'd73,    16'd99,
        16'd130,   16'd164,   16'd203,   16'd245,   16'd292,   16'd343,   16'd398,   16'd457,
        16'd520,   16'd587,   16'd658,   16'd733,   16'd812,   16'd895,   16'd983,   16'd1074,
        16'd1170,  16'd1269,  16'd1373,  16'd1481,  16'd1592,  16'd1708,  16'd1828,  16'd1952,
        16'd2080,  16'd2212,  16'd2348,  16'd2488,  16'd2632,  16'd2781,  16'd2933,  16'd3090,
        16'd3250,  16'd3415,  16'd3583,  16'd3756,  16'd3933,  16'd4114,  16'd4298,  16'd4487,
        16'd4680,  16'd4877,  16'd5079,  16'd5284,  16'd5493,  16'd5706,  16'd5924,  16'd6145,
        16'd6371,  16'd6600,  16'd6834,  16'd7072,  16'd7313,  16'd7559,  16'd7809,  16'd8063,
        16'd8321,  16'd8583,  16'd8849,  16'd9119,  16'd9394,  16'd9672,  16'd9954,  16'd10241,
        16'd10531, 16'd10826, 16'd11125, 16'd11427, 16'd11734, 16'd12045, 16'd12360, 16'd12679,
        16'd13002, 16'd13329, 16'd13660, 16'd13995, 16'd14335, 16'd14678, 16'd15025, 16'd15377,
        16'd15732, 16'd16092, 16'd16456, 16'd16823, 16'd17195, 16'd17571, 16'd17951, 16'd18335,
        16'd18723, 16'd19115, 16'd19511, 16'd19911, 16'd20316, 16'd20724, 16'd21136, 16'd21553,
        16'd21974, 16'd22398, 16'd22827, 16'd23260, 16'd23696, 16'd24137, 16'd24582, 16'd25031,
        16'd25484, 16'd25941, 16'd26402, 16'd26868, 16'd27337, 16'd27810, 16'd28288, 16'd28769,
        16'd29255, 16'd29744, 16'd30238, 16'd30736, 16'd31238, 16'd31744, 16'd32254, 16'd32768
    };

    // Floor-shift a gain product right by 15 and clamp to 16 bits
    function automatic logic signed [SAMPLE_W-1:0] sat16(input logic signed [PROD_W-1:0] p);
        logic signed [PROD_W-16:0] s;
        s = p[PROD_W-1:15];
        if (s > 18'sd32767) begin
            return 16'sh7fff;
        end else if (s < -18'sd32768) begin
            return 16'sh8000;
        end else begin
            return s[SAMPLE_W-1:0];
        end
    endfunction

endpackage

`default_nettype wire

// ===== rtl/volume_ramp_stereo_mixer.sv =====
// Sample pair: accepted in idle; result loaded in S_FIN once the output is not stalled.
// Volume command with ramp: S_PREP, then S_DIV, where the bit-serial restoring divider
// forms the per-sample delta one quotient bit a cycle, then S_DSET loads delta and ramp.
// Zero duration: level jumps in idle. Gain multiply is one shared 17x16 unit.
// Synchronous active-low reset: level 127.0, target 127, no ramp, stereo, 48 kHz ramp rate.
`default_nettype none

module volume_ramp_stereo_mixer
    import vrsm_pkg::*;
#(
    parameter int FRACTION_BITS = DEF_FRACTION_BITS
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    // input transaction channel
    input  wire logic                       i_valid,
    output logic                            o_stall,
    input  wire logic                       i_cmd,
    input  wire logic signed [SAMPLE_W-1:0] i_left_in,
    input  wire logic signed [SAMPLE_W-1:0] i_right_in,
    input  wire logic [IDX_W-1:0]           i_volume_target,
    input  wire logic [MS_W-1:0]            i_ramp_ms,
    // result channel
    output logic                            o_valid,
    input  wire logic                       i_stall,
    output logic signed [SAMPLE_W-1:0]      o_left_out,
    output logic signed [SAMPLE_W-1:0]      o_right_out,
    output logic [IDX_W-1:0]                o_level_used,
    // configuration write channel
    input  wire logic                       i_cfg_valid,
    output logic                            o_cfg_ready,
    input  wire logic                       i_cfg_index,
    input  wire logic                       i_cfg_data
);

    localparam int LW = FRACTION_BITS + IDX_W;   // level width, unsigned
    localparam int DW = LW + 1;                  // signed delta / difference width
    localparam int CW = $clog2(LW + 1);

    localparam logic [LW-1:0] LEVEL_MAX = {LW{1'b1}};

    t_state r_state, n_state;

    logic                       r_mono;
    logic                       r_rate48;
    logic [LW-1:0]              r_level;
    logic [IDX_W-1:0]           r_target;
    logic signed [DW-1:0]       r_delta;
    logic [CNT_W-1:0]           r_ramp;

    logic [MS_W-1:0]            r_ms;
    logic [CNT_W-1:0]           r_count;
    logic [LW-1:0]              r_dvd;
    logic [CNT_W-1:0]           r_rem;
    logic                       r_neg;
    logic [CW-1:0]              r_cnt;

    logic signed [SAMPLE_W-1:0] r_left;
    logic signed [SAMPLE_W-1:0] r_right;
    logic [GAIN_W-1:0]          r_gain;
    logic signed [PROD_W-1:0]   r_prod;
    logic signed [SAMPLE_W-1:0] r_left_sat;

    logic                       r_out_valid;
    logic signed [SAMPLE_W-1:0] r_out_l;
    logic signed [SAMPLE_W-1:0] r_out_r;
    logic [IDX_W-1:0]           r_out_idx;

    logic                       acc;
    logic                       out_load;
    logic                       cfg_we;

    logic [CNT_W-1:0]           count_32;
    logic [CNT_W-1:0]           count_val;
    logic signed [DW-1:0]       diff;
    logic [DW-1:0]              diff_mag;
    logic [CNT_W+1:0]           trial;
    logic                       trial_ge;
    logic signed [DW:0]         level_sum;
    logic [IDX_W-1:0]           level_idx;
    logic signed [PROD_W-1:0]   mul_out;
    logic signed [SAMPLE_W-1:0] right_sat;
    logic signed [SAMPLE_W-1:0] mono_mix;
    logic [MS_W-1:0]            ms_sat;

    // ---------------- control ----------------
    always_comb begin
        o_stall     = (r_state != S_IDLE);
        acc         = i_valid && (r_state == S_IDLE);
        out_load    = (r_state == S_FIN) && (!r_out_valid || !i_stall);
        o_cfg_ready = 1'b1;
        cfg_we      = i_cfg_valid;
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    if (i_cmd == CMD_SAMPLE) begin
                        n_state = S_STEP;
                    end else if (i_ramp_ms != '0) begin
                        n_state = S_PREP;
                    end
                end
            end
            S_PREP:  n_state = S_DIV;
            S_DIV: begin
                if (r_cnt == CW'(1)) begin
                    n_state = S_DSET;
                end
            end
            S_DSET:  n_state = S_IDLE;
            S_STEP:  n_state = S_GAIN;
            S_GAIN:  n_state = S_MUL_L;
            S_MUL_L: n_state = S_MUL_R;
            S_MUL_R: n_state = S_FIN;
            S_FIN: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // ---------------- datapath ----------------
    always_comb begin
        ms_sat    = (i_ramp_ms > MAX_RAMP_MS) ? MAX_RAMP_MS : i_ramp_ms;
        count_32  = {1'b0, r_ms, 5'b0};
        count_val = r_rate48 ? (count_32 + {2'b0, r_ms, 4'b0}) : count_32;
        diff      = $signed({1'b0, r_target, {FRACTION_BITS{1'b0}}})
                  - $signed({1'b0, r_level});
        diff_mag  = diff[DW-1] ? DW'(-diff) : DW'(diff);
        trial     = {1'b0, r_rem, r_dvd[LW-1]} - {2'b0, r_count};
        trial_ge  = !trial[CNT_W+1];
        level_sum = $signed({2'b0, r_level}) + $signed({r_delta[DW-1], r_delta});
        level_idx = r_level[LW-1 -: IDX_W];
        // shared multiplier: left sample in one state, right in the next
        mul_out   = $signed({1'b0, r_gain})
                  * ((r_state == S_MUL_L) ? r_left : r_right);
        right_sat = sat16(r_prod);
        mono_mix  = $signed({r_left_sat[SAMPLE_W-1], r_left_sat[SAMPLE_W-1:1]})
                  + $signed({right_sat[SAMPLE_W-1], right_sat[SAMPLE_W-1:1]});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_mono      <= 1'b0;
            r_rate48    <= 1'b1;
            r_level     <= {RESET_TARGET, {FRACTION_BITS{1'b0}}};
            r_target    <= RESET_TARGET;
            r_delta     <= '0;
            r_ramp      <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;

            if (cfg_we) begin
                if (i_cfg_index == CFG_MONO_OUTPUT) begin
                    r_mono <= i_cfg_data;
                end else begin
                    r_rate48 <= i_cfg_data;
                end
            end

            case (r_state)
                S_IDLE: begin
                    if (acc && (i_cmd == CMD_VOLUME)) begin
                        r_target <= i_volume_target;
                        r_ms     <= ms_sat;
                        if (i_ramp_ms == '0) begin
                            r_ramp  <= '0;
                            r_level <= {i_volume_target, {FRACTION_BITS{1'b0}}};
                        end
                    end
                end
                S_PREP: begin
                    r_count <= count_val;
                    r_dvd   <= diff_mag[LW-1:0];
                    r_neg   <= diff[DW-1];
                    r_rem   <= '0;
                    r_cnt   <= CW'(LW);
                end
                S_DIV: begin
                    // one restoring step: shift in dividend bit, subtract if it fits
                    r_rem <= trial_ge ? trial[CNT_W-1:0] : {r_rem[CNT_W-2:0], r_dvd[LW-1]};
                    r_dvd <= {r_dvd[LW-2:0], trial_ge};
                    r_cnt <= r_cnt - CW'(1);
                end
                S_DSET: begin
                    r_delta <= r_neg ? -$signed({1'b0, r_dvd}) : $signed({1'b0, r_dvd});
                    r_ramp  <= r_count;
                end
                S_STEP: begin
                    if (r_ramp != '0) begin
                        r_ramp <= r_ramp - CNT_W'(1);
                        if (level_sum < 0) begin
                            r_level <= '0;
                        end else if (level_sum > $signed({2'b0, LEVEL_MAX})) begin
                            r_level <= LEVEL_MAX;
                        end else begin
                            r_level <= level_sum[LW-1:0];
                        end
                    end else begin
                        r_level <= {r_target, {FRACTION_BITS{1'b0}}};
                    end
                end
                default: ;
            endcase

            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge i_clk) begin
        if (acc && (i_cmd == CMD_SAMPLE)) begin
            r_left  <= i_left_in;
            r_right <= i_right_in;
        end
        if (r_state == S_GAIN) begin
            r_gain <= GAIN_ROM[level_idx];
        end
        if ((r_state == S_MUL_L) || (r_state == S_MUL_R)) begin
            r_prod <= mul_out;
        end
        if (r_state == S_MUL_R) begin
            r_left_sat <= sat16(r_prod);
        end
        if (out_load) begin
            r_out_l   <= r_mono ? mono_mix : r_left_sat;
            r_out_r   <= r_mono ? mono_mix : right_sat;
            r_out_idx <= level_idx;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_left_out   = r_out_l;
    assign o_right_out  = r_out_r;
    assign o_level_used = r_out_idx;

`ifndef SYNTH
    // accepted sample pair always starts the level step next
    a_sample_to_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && (i_cmd == CMD_SAMPLE)) |=> (r_state == S_STEP))
        else $error("sample pair did not start level step");

    // immediate volume command leaves no ramp and stays ready
    a_jump_no_ramp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && (i_cmd == CMD_VOLUME) && (i_ramp_ms == '0))
        |=> ((r_ramp == '0) && !o_stall))
        else $error("immediate volume command left ramp armed");

    // divider has used every quotient bit when the delta is written
    a_div_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DSET) |-> (r_cnt == '0))
        else $error("delta written before division finished");

    // a finished ramp snaps the level to the target
    a_snap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_STEP) && (r_ramp == '0))
        |=> (r_level == {$past(r_target), {FRACTION_BITS{1'b0}}}))
        else $error("level did not snap to target");

    // result valid only rises out of the final sample state
    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == S_FIN))
        else $error("result raised outside final state");
`endif

endmodule

`default_nettype wire
